// ----- rtl/vzc_pkg.sv -----
package vzc_pkg;

    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 7;
    localparam int COUNT_W = 4;
    localparam int HALF_W  = 32;

    localparam logic [COUNT_W-1:0] LIMIT_NARROW = 4'd5;
    localparam logic [COUNT_W-1:0] LIMIT_WIDE   = 4'd10;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_VALUE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_DEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic enc_load;
        logic dec_take;
        logic enc_emit;
        logic dec_emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic enc_last;
        logic dec_done;
    } sts_t;

    function automatic logic [VALUE_W-1:0] zigzag_enc(input logic [VALUE_W-1:0] v);
        zigzag_enc = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
    endfunction

    // wide = 0 decodes at 32 bits, upper half forced to zero
    function automatic logic [VALUE_W-1:0] zigzag_dec(input logic [VALUE_W-1:0] v,
                                                      input logic wide);
        logic [VALUE_W-1:0] z;
        z = (v >> 1) ^ {VALUE_W{v[0]}};
        if (!wide)
        begin
            z[VALUE_W-1:HALF_W] = '0;
        end
        zigzag_dec = z;
    endfunction

endpackage

// ----- rtl/vzc_req_if.sv -----
interface vzc_req_if;
    import vzc_pkg::*;

    logic               valid;
    logic               ready;
    logic               func;
    logic               signed_mode;
    logic               wide_mode;
    logic [VALUE_W-1:0] value_in;
    logic [BYTE_W-1:0]  byte_in;

    modport source (output valid, func, signed_mode, wide_mode, value_in, byte_in,
                    input ready);
    modport sink   (input valid, func, signed_mode, wide_mode, value_in, byte_in,
                    output ready);
endinterface

// ----- rtl/vzc_rsp_if.sv -----
interface vzc_rsp_if;
    import vzc_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [BYTE_W-1:0]  byte_out;
    logic [VALUE_W-1:0] value_out;
    logic               last;

    modport source (output valid, kind, byte_out, value_out, last, input ready);
    modport sink   (input valid, kind, byte_out, value_out, last, output ready);
endinterface

// ----- rtl/vzc_ctrl.sv -----
module vzc_ctrl
    import vzc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_func,
    output logic req_ready,
    input  logic rsp_ready,
    output logic rsp_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_func == FUNC_DECODE) ? ST_DEC : ST_ENC;
                end
            end
            ST_ENC:
            begin
                if (slot_free && sts.enc_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC:
            begin
                if (!sts.dec_done || slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.enc_load = accept && (req_func == FUNC_ENCODE);
        cmd.dec_take = accept && (req_func == FUNC_DECODE);
        cmd.enc_emit = (state_reg == ST_ENC) && slot_free;
        cmd.dec_emit = (state_reg == ST_DEC) && sts.dec_done && slot_free;
        if (cmd.enc_emit || cmd.dec_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("request accepted but controller stayed idle");

    a_partial_byte_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEC && !sts.dec_done) |=> state_reg == ST_IDLE && !cmd.dec_emit)
        else $error("incomplete varint byte did not return to idle");

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.enc_emit || cmd.dec_emit) |-> (!out_valid_reg || rsp_ready))
        else $error("result overwrote an untaken result");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.enc_emit && cmd.dec_emit))
        else $error("encode and decode emitted together");

endmodule

// ----- rtl/vzc_dpath.sv -----
module vzc_dpath
    import vzc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               signed_mode,
    input  logic               wide_mode,
    input  logic [VALUE_W-1:0] value_in,
    input  logic [BYTE_W-1:0]  byte_in,
    output logic               kind,
    output logic [BYTE_W-1:0]  byte_out,
    output logic [VALUE_W-1:0] value_out,
    output logic               last
);

    // encode shifter
    logic [VALUE_W-1:0] enc_reg, enc_next;

    // decode state
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               wide_reg, wide_next;
    logic               sgn_reg, sgn_next;
    logic               done_reg, done_next;

    // result register
    logic               kind_reg, kind_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg, last_next;

    logic               first;
    logic               wide_eff;
    logic [6:0]         shamt;
    logic [VALUE_W-1:0] acc_base;
    logic [VALUE_W-1:0] group;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] limit;
    logic [VALUE_W-1:0] dec_raw;
    logic [VALUE_W-1:0] dec_val;

    assign sts.enc_last = (enc_reg[VALUE_W-1:GROUP_W] == '0);
    assign sts.dec_done = done_reg;

    // 7 * count, at most 63 for legal counts
    assign first     = (count_reg == '0);
    assign wide_eff  = first ? wide_mode : wide_reg;
    assign shamt     = {count_reg, 3'b000} - {3'b000, count_reg};
    assign acc_base  = first ? '0 : acc_reg;
    assign group     = shamt[6] ? '0
                                : ({{(VALUE_W-GROUP_W){1'b0}}, byte_in[GROUP_W-1:0]}
                                   << shamt[5:0]);
    assign count_inc = count_reg + 4'd1;
    assign limit     = wide_eff ? LIMIT_WIDE : LIMIT_NARROW;

    assign dec_raw = wide_reg ? acc_reg : {{HALF_W{1'b0}}, acc_reg[HALF_W-1:0]};
    assign dec_val = sgn_reg ? zigzag_dec(dec_raw, wide_reg) : dec_raw;

    always_comb
    begin
        enc_next   = enc_reg;
        acc_next   = acc_reg;
        count_next = count_reg;
        wide_next  = wide_reg;
        sgn_next   = sgn_reg;
        done_next  = done_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        value_next = value_reg;
        last_next  = last_reg;

        if (cmd.enc_load)
        begin
            enc_next = signed_mode ? zigzag_enc(value_in) : value_in;
        end
        if (cmd.enc_emit)
        begin
            kind_next  = KIND_BYTE;
            byte_next  = {!sts.enc_last, enc_reg[GROUP_W-1:0]};
            value_next = '0;
            last_next  = sts.enc_last;
            enc_next   = enc_reg >> GROUP_W;
        end

        if (cmd.dec_take)
        begin
            acc_next   = acc_base | group;
            count_next = count_inc;
            if (first)
            begin
                wide_next = wide_mode;
                sgn_next  = signed_mode;
            end
            done_next = !byte_in[BYTE_W-1] || (count_inc == limit);
        end
        if (cmd.dec_emit)
        begin
            kind_next  = KIND_VALUE;
            byte_next  = '0;
            value_next = dec_val;
            last_next  = 1'b1;
            acc_next   = '0;
            count_next = '0;
            wide_next  = 1'b0;
            sgn_next   = 1'b0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            wide_reg  <= 1'b0;
            sgn_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            wide_reg  <= wide_next;
            sgn_reg   <= sgn_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        enc_reg   <= enc_next;
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign kind      = kind_reg;
    assign byte_out  = byte_reg;
    assign value_out = value_reg;
    assign last      = last_reg;

endmodule

// ----- rtl/varint_zigzag_codec_core.sv -----
// Channel | Dir | Payload                                           | Handshake
// req     | in  | func, signed_mode, wide_mode, value_in, byte_in   | valid/ready
// rsp     | out | kind, byte_out, value_out, last                   | valid/ready
//
// Encode: the request is taken, then one byte per cycle from the 64-bit shifter
//   while the result register is free, 1 to 10 bytes per request.
// Decode: per byte, a take step, then a complete/emit step from the accumulator.
// Reset clears the controller and the decode accumulator, count and modes.
// One result register sits on rsp; a full register stalls only the emit
// step, so a new request is taken while the last result waits.
module varint_zigzag_codec_core
    import vzc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    vzc_req_if.sink   req,
    vzc_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    // FSM: idle -> encode emit loop, or idle -> decode step
    vzc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_func  (req.func),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // shifter, accumulator, zigzag mapping and result register
    vzc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .signed_mode (req.signed_mode),
        .wide_mode   (req.wide_mode),
        .value_in    (req.value_in),
        .byte_in     (req.byte_in),
        .kind        (rsp.kind),
        .byte_out    (rsp.byte_out),
        .value_out   (rsp.value_out),
        .last        (rsp.last)
    );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vzc_pkg::*;

    // Cycles without any request or result moving before the run is declared hung.
    // The slowest legal stretch is a ten-byte encode under heavy receiver
    // stalls, which stays far below this.
    localparam int WATCHDOG_LIMIT = 2000;
    // Pause after the last result.
    // The core holds at most one request and one result register.
    localparam int DRAIN_CYCLES = 24;

    typedef struct packed {
        logic               func;
        logic               signed_mode;
        logic               wide_mode;
        logic [VALUE_W-1:0] value_in;
        logic [BYTE_W-1:0]  byte_in;
    } codec_req_t;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  byte_out;
        logic [VALUE_W-1:0] value_out;
        logic               last;
    } codec_rsp_t;

    logic clk;
    logic rst_n;

    vzc_req_if req_ch ();
    vzc_rsp_if rsp_ch ();

    varint_zigzag_codec_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the decoder state.
    // It mirrors the accumulator, the byte count and the modes that the
    // first byte of a value latched.
    logic [VALUE_W-1:0] dec_acc;
    logic [COUNT_W-1:0] dec_cnt;
    logic               dec_wide;
    logic               dec_signed;

    codec_rsp_t results_due[$];

    int errors;
    int sent_items;
    int n_enc_reqs;
    int n_dec_bytes;
    int n_checked;
    int send_idle_pct;
    int recv_stall_pct;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_result(input logic kind, input logic [BYTE_W-1:0] b,
                                input logic [VALUE_W-1:0] v, input logic last);
        codec_rsp_t r;
        r.kind      = kind;
        r.byte_out  = b;
        r.value_out = v;
        r.last      = last;
        results_due.insert(results_due.size(), r);
    endtask

    // Works out what one accepted request produces.
    // An encode request yields its bytes. A decode byte yields the value,
    // or nothing while the value is still open.
    task automatic predict_codec_step(input codec_req_t r);
        logic [VALUE_W-1:0] v;
        logic [COUNT_W-1:0] lim;
        int unsigned        shift;
        if (r.func == FUNC_ENCODE)
        begin
            v = r.value_in;
            // zigzag: shift left, fold the sign into every bit
            if (r.signed_mode)
                v = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
            while (v >= 64'h80)
            begin
                queue_result(KIND_BYTE, {1'b1, v[GROUP_W-1:0]}, '0, 1'b0);
                v = v >> GROUP_W;
            end
            queue_result(KIND_BYTE, v[BYTE_W-1:0], '0, 1'b1);
        end
        else
        begin
            // modes come from the first byte of a value only
            if (dec_cnt == 0)
            begin
                dec_wide   = r.wide_mode;
                dec_signed = r.signed_mode;
                dec_acc    = '0;
            end
            shift = GROUP_W * dec_cnt;
            if (shift < VALUE_W)
                dec_acc = dec_acc |
                          ({{(VALUE_W-GROUP_W){1'b0}}, r.byte_in[GROUP_W-1:0]} << shift);
            dec_cnt = dec_cnt + 1'b1;
            lim = dec_wide ? LIMIT_WIDE : LIMIT_NARROW;
            // the value closes on a byte with bit 7 clear or at the byte limit
            if (!r.byte_in[BYTE_W-1] || dec_cnt >= lim)
            begin
                v = dec_acc;
                if (!dec_wide)
                    v[VALUE_W-1:HALF_W] = '0;
                if (dec_signed)
                begin
                    v = (v >> 1) ^ {VALUE_W{v[0]}};
                    if (!dec_wide)
                        v[VALUE_W-1:HALF_W] = '0;
                end
                queue_result(KIND_VALUE, '0, v, 1'b1);
                dec_acc    = '0;
                dec_cnt    = '0;
                dec_wide   = 1'b0;
                dec_signed = 1'b0;
            end
        end
    endtask

    // Drives one request and holds it until it is taken.
    // Valid stays high after the handshake, so back-to-back requests never
    // lower and raise it in one step. It is only dropped to open a gap.
    task automatic send_req(input codec_req_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= r.func;
        req_ch.signed_mode <= r.signed_mode;
        req_ch.wide_mode   <= r.wide_mode;
        req_ch.value_in    <= r.value_in;
        req_ch.byte_in     <= r.byte_in;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_codec_step(r);
        sent_items++;
    endtask

    function automatic logic [VALUE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Encode values of spread lengths, so that every byte count from 1 to 10 shows up.
    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return rand_word();
            1: return rand_word() >> $urandom_range(63);
            2: return ~(rand_word() >> $urandom_range(63));
            default:
            begin
                case ($urandom_range(5))
                    0: return '0;
                    1: return '1;
                    2: return 64'h8000_0000_0000_0000;
                    3: return 64'h7FFF_FFFF_FFFF_FFFF;
                    4: return 64'h7F;
                    default: return 64'h80;
                endcase
            end
        endcase
    endfunction

    // Fields that the operation ignores still get random content.
    task automatic send_encode(input logic [VALUE_W-1:0] v, input logic sgn);
        codec_req_t r;
        r.func        = FUNC_ENCODE;
        r.signed_mode = sgn;
        r.wide_mode   = 1'($urandom_range(1));
        r.value_in    = v;
        r.byte_in     = BYTE_W'($urandom);
        n_enc_reqs++;
        send_req(r);
    endtask

    task automatic send_decode(input logic [BYTE_W-1:0] b, input logic wide,
                               input logic sgn);
        codec_req_t r;
        r.func        = FUNC_DECODE;
        r.signed_mode = sgn;
        r.wide_mode   = wide;
        r.value_in    = rand_word();
        r.byte_in     = b;
        n_dec_bytes++;
        send_req(r);
    endtask

    // One well-formed varint, sometimes cut by an encode request.
    // Later bytes carry random modes, which the core must ignore. At the
    // byte limit, bit 7 of the final byte is random.
    task automatic send_decode_run();
        logic              wide;
        logic              sgn;
        int unsigned       lim;
        int unsigned       n;
        logic [BYTE_W-1:0] b;
        wide = 1'($urandom_range(1));
        sgn  = 1'($urandom_range(1));
        lim  = wide ? 32'(LIMIT_WIDE) : 32'(LIMIT_NARROW);
        n    = ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                send_encode(rand_value(), 1'($urandom_range(1)));
            b = BYTE_W'($urandom);
            if (i < n - 1)
                b[BYTE_W-1] = 1'b1;
            else if (n < lim)
                b[BYTE_W-1] = 1'b0;
            if (i == 0)
                send_decode(b, wide, sgn);
            else
                send_decode(b, 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_encode_extremes();
        send_encode(64'h0, 1'b0);
        send_encode(64'h80, 1'b0);
        send_encode('1, 1'b0);
        send_encode('1, 1'b1);
        send_encode(64'h8000_0000_0000_0000, 1'b1);
        send_encode(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_decode_limits();
        // signed 32-bit -1
        send_decode(8'h01, 1'b0, 1'b1);
        // five bytes with bit 7 set: the byte limit closes the value, bits above 31 drop
        repeat (5) send_decode(8'hFF, 1'b0, 1'b0);
        // ten bytes, signed wide: the limit closes the value, bits past 63 drop
        repeat (10) send_decode(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_mode_latch();
        // the second byte asks for wide signed mode, which must be ignored
        send_decode(8'h80, 1'b0, 1'b0);
        send_decode(8'h01, 1'b1, 1'b1);
    endtask

    task automatic test_encode_mid_decode();
        send_decode(8'h81, 1'b1, 1'b0);
        send_encode(64'h7F, 1'b0);
        send_decode(8'h01, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic(input int n_items, input int s_idle, input int r_stall);
        int target;
        int pick;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        target = sent_items + n_items;
        while (sent_items < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                send_encode(rand_value(), 1'($urandom_range(1)));
            else if (pick < 45)
                send_decode(BYTE_W'($urandom), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
            else
                send_decode_run();
        end
    endtask

    // ---------------------------------------------------------------- result side

    task automatic check_result();
        codec_rsp_t want;
        if (results_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind=%0b byte=%h value=%h last=%0b",
                                      rsp_ch.kind, rsp_ch.byte_out, rsp_ch.value_out,
                                      rsp_ch.last));
        end
        else
        begin
            want = results_due.pop_front();
            n_checked++;
            if (rsp_ch.kind !== want.kind)
                report_mismatch($sformatf("kind got %0b want %0b", rsp_ch.kind, want.kind));
            if (rsp_ch.byte_out !== want.byte_out)
                report_mismatch($sformatf("byte_out got %h want %h",
                                          rsp_ch.byte_out, want.byte_out));
            if (rsp_ch.value_out !== want.value_out)
                report_mismatch($sformatf("value_out got %h want %h",
                                          rsp_ch.value_out, want.value_out));
            if (rsp_ch.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", rsp_ch.last, want.last));
        end
    endtask

    // Sample at the edge, then redraw ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result();
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: nothing moved for %0d cycles, %0d results still due",
                 WATCHDOG_LIMIT, results_due.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_ENCODE;
        req_ch.signed_mode = 1'b0;
        req_ch.wide_mode   = 1'b0;
        req_ch.value_in    = '0;
        req_ch.byte_in     = '0;
        rsp_ch.ready       = 1'b0;
        dec_acc            = '0;
        dec_cnt            = '0;
        dec_wide           = 1'b0;
        dec_signed         = 1'b0;
        errors             = 0;
        sent_items         = 0;
        n_enc_reqs         = 0;
        n_dec_bytes        = 0;
        n_checked          = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_encode_extremes();
        test_decode_limits();
        test_mode_latch();
        test_encode_mid_decode();

        // random traffic in four idle profiles: none, sender, receiver, both lightly
        test_random_traffic(45, 0, 0);
        test_random_traffic(45, 47, 0);
        test_random_traffic(45, 0, 47);
        test_random_traffic(45, 9, 9);

        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d encode requests and %0d decode bytes; %0d results checked",
                 n_enc_reqs, n_dec_bytes, n_checked);
        $display("idle profiles: none, sender 47%%, receiver 47%%, both 9%%; %0d mismatches",
                 errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/vzc_pkg.sv
rtl/vzc_req_if.sv
rtl/vzc_rsp_if.sv
rtl/vzc_ctrl.sv
rtl/vzc_dpath.sv
rtl/varint_zigzag_codec_core.sv
tb/sv/testbench.sv
